// ===== rtl/core/sprite_frame_sequencer_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the sprite frame sequencer
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef SPRITE_FRAME_SEQUENCER_ASSERT_SVH
`define SPRITE_FRAME_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define SFS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sprite_frame_sequencer: check failed");

// Condition must never be true outside reset.
`define SFS_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("sprite_frame_sequencer: forbidden condition");

`else

`define SFS_ASSERT(lbl, clk, rst_n, prop)
`define SFS_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== rtl/core/sfs_pkg.sv =====
// ---------------------------------------------------------------------------
// Sprite frame sequencer package
// Field widths, item kinds, register indexes and sequencer states.
// ---------------------------------------------------------------------------
package sfs_pkg;

    localparam int IDX_W     = 10;   // frame and sprite index
    localparam int ACCUM_W   = 24;   // time accumulator and frame period
    localparam int DELTA_W   = 16;
    localparam int LOOP_W    = 16;
    localparam int COLS_W    = 7;
    localparam int SIZE_W    = 10;   // frame width / height
    localparam int COORD_W   = 16;
    localparam int SLOT_W    = 6;
    localparam int KIND_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 48;
    localparam int CNT_W     = 4;    // divider step counter
    localparam int DIV_STEPS = IDX_W;

    localparam int LIST_DEPTH_DEF = 64;

    // Reset values of the configuration registers
    localparam logic [IDX_W-1:0]   RST_END    = 10'd1;
    localparam logic [LOOP_W-1:0]  RST_LIMIT  = 16'hFFFF;
    localparam logic [COLS_W-1:0]  RST_COLS   = 7'd1;
    localparam logic [SIZE_W-1:0]  RST_SIZE   = 10'd16;
    localparam logic [ACCUM_W-1:0] RST_PERIOD = 24'd100000;
    localparam logic [LOOP_W-1:0]  LOOP_FOREVER = 16'hFFFF;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK   = 3'd0,
        KIND_PLAY   = 3'd1,
        KIND_PAUSE  = 3'd2,
        KIND_STOP   = 3'd3,
        KIND_SELECT = 3'd4,
        KIND_LIST   = 3'd5
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIST_MODE = 3'd0,
        CFG_START     = 3'd1,
        CFG_END       = 3'd2,
        CFG_LOOP_LIM  = 3'd3,
        CFG_COLUMNS   = 3'd4,
        CFG_FRAME_W   = 3'd5,
        CFG_FRAME_H   = 3'd6,
        CFG_PERIOD    = 3'd7
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ADV,
        S_MEM,
        S_DIV,
        S_MULX,
        S_MULY,
        S_DONE
    } t_state;

endpackage

// ===== rtl/core/sprite_frame_sequencer.sv =====
// ---------------------------------------------------------------------------
// Sprite frame sequencer
// Steps sprite-sheet animation frames and computes the source rectangle.
// ---------------------------------------------------------------------------
// Usage:
//  - Input items arrive on s_axis: tuser carries the kind (tick, play, pause,
//    stop, select, list write), tdata the delta time, flag, sprite index and
//    list slot. Every item gives exactly one result item on m_axis: the
//    rectangle origin, the current frame position and the play/stop flags.
//  - Configuration is written on i_cfg_we/i_cfg_index/i_cfg_data, one
//    register per cycle; users write only with no item in flight (unchecked).
//  - Sequencing: control items pass S_EXEC and S_DONE; a select adds the
//    10-step restoring divider by the column count and the two passes
//    through the shared multiplier, and a tick that advances a frame also
//    passes S_ADV (range) or S_ADV and S_MEM (list) before them. One item is
//    in work at a time: the next is accepted only after the last leaves S_DONE.
//  - The result sits in an output register, so the next item is accepted
//    while an earlier result still waits for m_axis_tready. A stalled
//    receiver holds the sequencer in its last step until the register frees.
//  - Synchronous active-low reset clears the playback state and loads the
//    register defaults. The index list has no reset; read only written slots.
// ---------------------------------------------------------------------------
`include "sprite_frame_sequencer_assert.svh"

module sprite_frame_sequencer #(
    parameter int LIST_DEPTH = sfs_pkg::LIST_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [sfs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sfs_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    // input items
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // delta_time[15:0], flag[16], sprite_index[26:17], list_slot[32:27]
    input  logic [sfs_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // kind[2:0]
    input  logic [sfs_pkg::KIND_W-1:0]       s_axis_tuser,
    // result items
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // rect_x[15:0], rect_y[31:16], frame_index[41:32], playing[42], stopped[43]
    output logic [sfs_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int IDX_W = sfs_pkg::IDX_W;
    localparam int EXT_W = IDX_W + 1;
    localparam logic [EXT_W-1:0] DEPTH_EXT = EXT_W'(LIST_DEPTH);
    localparam int PROD_W = IDX_W + sfs_pkg::SIZE_W;

    // ---------------- configuration registers ----------------
    logic                              r_list_mode;
    logic [IDX_W-1:0]                  r_start;
    logic [IDX_W-1:0]                  r_end;
    logic [sfs_pkg::LOOP_W-1:0]        r_loop_limit;
    logic [sfs_pkg::COLS_W-1:0]        r_cols;
    logic [sfs_pkg::SIZE_W-1:0]        r_frame_w;
    logic [sfs_pkg::SIZE_W-1:0]        r_frame_h;
    logic [sfs_pkg::ACCUM_W-1:0]       r_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list_mode  <= 1'b0;
            r_start      <= '0;
            r_end        <= sfs_pkg::RST_END;
            r_loop_limit <= sfs_pkg::RST_LIMIT;
            r_cols       <= sfs_pkg::RST_COLS;
            r_frame_w    <= sfs_pkg::RST_SIZE;
            r_frame_h    <= sfs_pkg::RST_SIZE;
            r_period     <= sfs_pkg::RST_PERIOD;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sfs_pkg::CFG_LIST_MODE: r_list_mode  <= i_cfg_data[0];
                sfs_pkg::CFG_START:     r_start      <= i_cfg_data[IDX_W-1:0];
                sfs_pkg::CFG_END:       r_end        <= i_cfg_data[IDX_W-1:0];
                sfs_pkg::CFG_LOOP_LIM:  r_loop_limit <= i_cfg_data[sfs_pkg::LOOP_W-1:0];
                sfs_pkg::CFG_COLUMNS:   r_cols       <= i_cfg_data[sfs_pkg::COLS_W-1:0];
                sfs_pkg::CFG_FRAME_W:   r_frame_w    <= i_cfg_data[sfs_pkg::SIZE_W-1:0];
                sfs_pkg::CFG_FRAME_H:   r_frame_h    <= i_cfg_data[sfs_pkg::SIZE_W-1:0];
                sfs_pkg::CFG_PERIOD:    r_period     <= i_cfg_data[sfs_pkg::ACCUM_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- item latch ----------------
    logic [sfs_pkg::KIND_W-1:0]   r_kind;
    logic [sfs_pkg::DELTA_W-1:0]  r_delta;
    logic                         r_flag;
    logic [IDX_W-1:0]             r_sidx;
    logic [sfs_pkg::SLOT_W-1:0]   r_slot;
    logic                         w_in_acc;

    assign w_in_acc = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_kind  <= s_axis_tuser;
            r_delta <= s_axis_tdata[15:0];
            r_flag  <= s_axis_tdata[16];
            r_sidx  <= s_axis_tdata[26:17];
            r_slot  <= s_axis_tdata[32:27];
        end
    end

    // ---------------- playback state ----------------
    sfs_pkg::t_state              r_state, n_state;
    logic [IDX_W-1:0]             r_position, n_position;
    logic [sfs_pkg::ACCUM_W-1:0]  r_accum, n_accum;
    logic [sfs_pkg::LOOP_W-1:0]   r_loop_count, n_loop_count;
    logic                         r_paused, n_paused;
    logic                         r_halted, n_halted;
    logic                         r_active, n_active;
    logic [sfs_pkg::COORD_W-1:0]  r_origin_x, n_origin_x;
    logic [sfs_pkg::COORD_W-1:0]  r_origin_y, n_origin_y;

    // shared divide / multiply datapath
    logic [IDX_W-1:0]             r_quo, n_quo;      // dividend in, quotient out
    logic [sfs_pkg::COLS_W-1:0]   r_rem, n_rem;
    logic [sfs_pkg::CNT_W-1:0]    r_cnt, n_cnt;

    // output register
    logic                         r_out_valid;
    logic [sfs_pkg::OUT_DATA_W-1:0] r_out_data;
    logic                         w_out_load;

    // index list
    logic [IDX_W-1:0]             r_list_mem [LIST_DEPTH];
    logic [IDX_W-1:0]             r_rd_data;
    logic                         w_mem_we;
    logic [AW-1:0]                w_wr_addr;
    logic [AW-1:0]                w_rd_addr;
    logic [EXT_W-1:0]             w_slot_ext;
    logic [EXT_W-1:0]             w_npos_ext;

    // combinational helpers
    logic [sfs_pkg::ACCUM_W:0]    w_sum;
    logic [sfs_pkg::ACCUM_W-1:0]  w_sum_sat;
    logic [EXT_W-1:0]             w_next;
    logic [EXT_W-1:0]             w_len;
    logic                         w_wrap;
    logic [sfs_pkg::LOOP_W-1:0]   w_cnt_inc;
    logic signed [sfs_pkg::LOOP_W:0] w_cnt_s;
    logic signed [sfs_pkg::LOOP_W:0] w_lim_s;
    logic                         w_lim_hit;
    logic [IDX_W-1:0]             w_new_pos;
    logic [sfs_pkg::COLS_W-1:0]   w_cols;
    logic [sfs_pkg::COLS_W:0]     w_trial;
    logic                         w_ge;
    logic [IDX_W-1:0]             w_mul_a;
    logic [sfs_pkg::SIZE_W-1:0]   w_mul_b;
    logic [PROD_W-1:0]            w_prod;
    logic [sfs_pkg::COORD_W-1:0]  w_prod_sat;

    // time accumulate with saturation
    assign w_sum     = {1'b0, r_accum} + (sfs_pkg::ACCUM_W+1)'(r_delta);
    assign w_sum_sat = w_sum[sfs_pkg::ACCUM_W] ? '1 : w_sum[sfs_pkg::ACCUM_W-1:0];

    // frame advance: list length is clamped to storage depth
    assign w_next = {1'b0, r_position} + EXT_W'(1);
    assign w_len  = ({1'b0, r_end} < DEPTH_EXT) ? {1'b0, r_end} : DEPTH_EXT;
    assign w_wrap = r_list_mode ? (w_next >= w_len) : (w_next >= {1'b0, r_end});
    assign w_new_pos = w_wrap ? (r_list_mode ? '0 : r_start) : w_next[IDX_W-1:0];

    // loop count saturates; -1 limit loops forever
    assign w_cnt_inc = (r_loop_count != '1) ? r_loop_count + 1'b1 : r_loop_count;
    assign w_cnt_s   = $signed({1'b0, w_cnt_inc});
    assign w_lim_s   = $signed({r_loop_limit[sfs_pkg::LOOP_W-1], r_loop_limit});
    assign w_lim_hit = (r_loop_limit != sfs_pkg::LOOP_FOREVER) && (w_cnt_s > w_lim_s);

    // restoring divider step, one quotient bit per cycle
    assign w_cols  = (r_cols == '0) ? sfs_pkg::COLS_W'(1) : r_cols;
    assign w_trial = {r_rem, r_quo[IDX_W-1]};
    assign w_ge    = w_trial >= {1'b0, w_cols};

    // shared multiplier: column * width, then row * height
    assign w_mul_a    = (r_state == sfs_pkg::S_MULX) ? IDX_W'(r_rem) : r_quo;
    assign w_mul_b    = (r_state == sfs_pkg::S_MULX) ? r_frame_w : r_frame_h;
    assign w_prod     = w_mul_a * w_mul_b;
    assign w_prod_sat = (|w_prod[PROD_W-1:sfs_pkg::COORD_W]) ? '1
                                                            : w_prod[sfs_pkg::COORD_W-1:0];

    assign w_slot_ext = EXT_W'(r_slot);
    assign w_npos_ext = EXT_W'(w_new_pos);
    assign w_wr_addr  = w_slot_ext[AW-1:0];
    assign w_rd_addr  = w_npos_ext[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= sfs_pkg::S_IDLE;
            r_position   <= '0;
            r_accum      <= '0;
            r_loop_count <= '0;
            r_paused     <= 1'b0;
            r_halted     <= 1'b0;
            r_active     <= 1'b0;
            r_origin_x   <= '0;
            r_origin_y   <= '0;
            r_cnt        <= '0;
        end else begin
            r_state      <= n_state;
            r_position   <= n_position;
            r_accum      <= n_accum;
            r_loop_count <= n_loop_count;
            r_paused     <= n_paused;
            r_halted     <= n_halted;
            r_active     <= n_active;
            r_origin_x   <= n_origin_x;
            r_origin_y   <= n_origin_y;
            r_cnt        <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    always_comb begin
        n_state      = r_state;
        n_position   = r_position;
        n_accum      = r_accum;
        n_loop_count = r_loop_count;
        n_paused     = r_paused;
        n_halted     = r_halted;
        n_active     = r_active;
        n_origin_x   = r_origin_x;
        n_origin_y   = r_origin_y;
        n_quo        = r_quo;
        n_rem        = r_rem;
        n_cnt        = r_cnt;
        w_mem_we     = 1'b0;
        w_out_load   = 1'b0;
        s_axis_tready = 1'b0;

        case (r_state)
            sfs_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = sfs_pkg::S_EXEC;
                end
            end

            sfs_pkg::S_EXEC: begin
                n_state = sfs_pkg::S_DONE;
                case (r_kind)
                    sfs_pkg::KIND_TICK: begin
                        if (r_paused || r_halted) begin
                            n_active = 1'b0;
                        end else begin
                            n_accum = w_sum_sat;
                            if (w_sum_sat > r_period) begin
                                n_state = sfs_pkg::S_ADV;
                            end
                        end
                    end
                    sfs_pkg::KIND_PLAY: begin
                        n_accum      = '0;
                        n_loop_count = '0;
                        n_position   = r_list_mode ? '0 : r_start;
                        if (r_flag) begin
                            n_paused = 1'b0;
                            n_halted = 1'b0;
                            n_active = 1'b1;
                        end
                    end
                    sfs_pkg::KIND_PAUSE: begin
                        n_paused = r_flag;
                    end
                    sfs_pkg::KIND_STOP: begin
                        n_halted = r_flag;
                        if (r_flag) begin
                            n_active = 1'b0;
                        end
                    end
                    sfs_pkg::KIND_SELECT: begin
                        n_paused = 1'b1;
                        n_quo    = r_sidx;
                        n_rem    = '0;
                        n_cnt    = '0;
                        n_state  = sfs_pkg::S_DIV;
                    end
                    sfs_pkg::KIND_LIST: begin
                        w_mem_we = (w_slot_ext < DEPTH_EXT);
                    end
                    default: ;
                endcase
            end

            sfs_pkg::S_ADV: begin
                n_accum    = '0;
                n_position = w_new_pos;
                if (w_wrap) begin
                    n_loop_count = w_cnt_inc;
                    if (w_lim_hit) begin
                        n_halted = 1'b1;
                    end
                end
                n_rem = '0;
                n_cnt = '0;
                if (r_list_mode) begin
                    n_state = sfs_pkg::S_MEM;
                end else begin
                    n_quo   = w_new_pos;
                    n_state = sfs_pkg::S_DIV;
                end
            end

            sfs_pkg::S_MEM: begin
                // positions past storage show sprite zero
                n_quo   = ({1'b0, r_position} < DEPTH_EXT) ? r_rd_data : '0;
                n_state = sfs_pkg::S_DIV;
            end

            sfs_pkg::S_DIV: begin
                n_quo = {r_quo[IDX_W-2:0], w_ge};
                n_rem = w_ge ? sfs_pkg::COLS_W'(w_trial - {1'b0, w_cols})
                             : w_trial[sfs_pkg::COLS_W-1:0];
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == sfs_pkg::CNT_W'(sfs_pkg::DIV_STEPS - 1)) begin
                    n_state = sfs_pkg::S_MULX;
                end
            end

            sfs_pkg::S_MULX: begin
                n_origin_x = w_prod_sat;
                n_state    = sfs_pkg::S_MULY;
            end

            sfs_pkg::S_MULY: begin
                n_origin_y = w_prod_sat;
                n_state    = sfs_pkg::S_DONE;
            end

            sfs_pkg::S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    w_out_load = 1'b1;
                    n_state    = sfs_pkg::S_IDLE;
                end
            end

            default: n_state = sfs_pkg::S_IDLE;
        endcase
    end

    // ---------------- index list memory ----------------
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_list_mem[w_wr_addr] <= r_sidx;
        end
        r_rd_data <= r_list_mem[w_rd_addr];
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= {4'b0, r_halted, r_active, r_position, r_origin_y, r_origin_x};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // ---------------- checks ----------------
    `SFS_ASSERT(a_accept_exec, i_clk, i_rst_n, w_in_acc |=> (r_state == sfs_pkg::S_EXEC))
    `SFS_ASSERT(a_div_bound, i_clk, i_rst_n, (r_state == sfs_pkg::S_DIV) |-> (r_cnt < sfs_pkg::CNT_W'(sfs_pkg::DIV_STEPS)))
    `SFS_ASSERT(a_load_valid, i_clk, i_rst_n, w_out_load |=> m_axis_tvalid)
    `SFS_ASSERT(a_halt_src, i_clk, i_rst_n, $rose(r_halted) |-> ($past(r_state) == sfs_pkg::S_EXEC || $past(r_state) == sfs_pkg::S_ADV))
    `SFS_NEVER(a_load_busy, i_clk, i_rst_n, w_out_load && r_out_valid && !m_axis_tready)

endmodule

// ===== dv/testbench.sv =====
// ---------------------------------------------------------------------------
// Sprite frame sequencer testbench
// Drives input items through a stimulus table and then random playback sequences, and
// checks every result item against an in-bench behavioral model of the sequencer or
// the hand-typed result of a pinned row. Both stream sides idle and stall at random.
// ---------------------------------------------------------------------------
module testbench;

    localparam int KIND_W     = sfs_pkg::KIND_W;
    localparam int DELTA_W    = sfs_pkg::DELTA_W;
    localparam int IDX_W      = sfs_pkg::IDX_W;
    localparam int SLOT_W     = sfs_pkg::SLOT_W;
    localparam int COORD_W    = sfs_pkg::COORD_W;
    localparam int LOOP_W     = sfs_pkg::LOOP_W;
    localparam int COLS_W     = sfs_pkg::COLS_W;
    localparam int SIZE_W     = sfs_pkg::SIZE_W;
    localparam int ACCUM_W    = sfs_pkg::ACCUM_W;
    localparam int CFG_IDX_W  = sfs_pkg::CFG_IDX_W;
    localparam int CFG_DAT_W  = sfs_pkg::CFG_DAT_W;
    localparam int IN_DATA_W  = sfs_pkg::IN_DATA_W;
    localparam int OUT_DATA_W = sfs_pkg::OUT_DATA_W;

    localparam int SHEET_SLOTS    = sfs_pkg::LIST_DEPTH_DEF;
    localparam int DRAIN_CYCLES   = 20;      // margin past the longest item
    localparam int WATCHDOG_LIMIT = 4000;    // cycles with no item moving

    // kinds the block must treat as no-ops
    localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [DELTA_W-1:0] delta;
        logic               flag;
        logic [IDX_W-1:0]   sprite;
        logic [SLOT_W-1:0]  slot;
    } t_anim_item;

    typedef struct packed {
        logic [COORD_W-1:0] rect_x;
        logic [COORD_W-1:0] rect_y;
        logic [IDX_W-1:0]   frame_index;
        logic               playing;
        logic               stopped;
    } t_frame_result;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_op;

    // one line of the directed stimulus; 'pinned' rows carry a hand-typed result
    typedef struct packed {
        t_row_op              op;
        sfs_pkg::t_cfg_reg    cfg_sel;
        logic [CFG_DAT_W-1:0] cfg_val;
        t_anim_item           item;
        logic                 pinned;
        t_frame_result        want;
    } t_stim_row;

    // -----------------------------------------------------------------------
    // DUT hookup
    // -----------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DAT_W-1:0]  i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;    // delta, flag, sprite, slot
    logic [KIND_W-1:0]     s_axis_tuser = '0;    // kind
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // rect_x, rect_y, index, playing, stopped

    sprite_frame_sequencer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // -----------------------------------------------------------------------
    // Sequencer model: register mirror and playback state
    // -----------------------------------------------------------------------
    logic                     cfg_list_mode = 1'b0;
    logic [IDX_W-1:0]         cfg_start     = '0;
    logic [IDX_W-1:0]         cfg_end       = sfs_pkg::RST_END;
    logic signed [LOOP_W-1:0] cfg_loop_lim  = sfs_pkg::RST_LIMIT;
    logic [COLS_W-1:0]        cfg_cols      = sfs_pkg::RST_COLS;
    logic [SIZE_W-1:0]        cfg_fw        = sfs_pkg::RST_SIZE;
    logic [SIZE_W-1:0]        cfg_fh        = sfs_pkg::RST_SIZE;
    logic [ACCUM_W-1:0]       cfg_period    = sfs_pkg::RST_PERIOD;

    logic [IDX_W-1:0]   seq_pos    = '0;
    logic [ACCUM_W-1:0] seq_accum  = '0;
    logic [LOOP_W-1:0]  seq_loops  = '0;
    logic               seq_paused = 1'b0;
    logic               seq_halted = 1'b0;
    logic               seq_active = 1'b0;
    logic [COORD_W-1:0] org_x      = '0;
    logic [COORD_W-1:0] org_y      = '0;
    logic [IDX_W-1:0]   sheet_list [SHEET_SLOTS];

    t_frame_result frame_q [$];     // results owed by the block, oldest first
    int            err_count = 0;
    int            gap_pct   = 0;   // sender idle chance per cycle
    int            stall_pct = 0;   // receiver stall chance per cycle
    int            idle_cycles = 0;

    // Source rectangle of a sheet index; zero columns behaves as one column,
    // and both coordinates clamp at the top of their range.
    function automatic void place_origin(logic [IDX_W-1:0] idx);
        int cols;
        int x;
        int y;
        cols = (cfg_cols == 0) ? 1 : int'(cfg_cols);
        x = (int'(idx) % cols) * int'(cfg_fw);
        y = (int'(idx) / cols) * int'(cfg_fh);
        org_x = (x > 65535) ? 16'hFFFF : x[COORD_W-1:0];
        org_y = (y > 65535) ? 16'hFFFF : y[COORD_W-1:0];
    endfunction

    // One more wrap; a limit of -1 plays forever, any other limit halts once passed.
    function automatic void bump_loop();
        int lim;
        lim = int'(cfg_loop_lim);
        if (seq_loops != 16'hFFFF) begin
            seq_loops = seq_loops + 1'b1;
        end
        if (lim != -1 && int'(seq_loops) > lim) begin
            seq_halted = 1'b1;
        end
    endfunction

    function automatic void step_frame();
        int nxt;
        int len;
        nxt = int'(seq_pos) + 1;
        if (!cfg_list_mode) begin
            if (nxt >= int'(cfg_end)) begin
                bump_loop();
                nxt = int'(cfg_start);
            end
            seq_pos = nxt[IDX_W-1:0];
            place_origin(seq_pos);
        end else begin
            // list length is capped by the storage depth
            len = (int'(cfg_end) < SHEET_SLOTS) ? int'(cfg_end) : SHEET_SLOTS;
            if (nxt >= len) begin
                bump_loop();
                nxt = 0;
            end
            seq_pos = nxt[IDX_W-1:0];
            place_origin((seq_pos < SHEET_SLOTS) ? sheet_list[seq_pos[SLOT_W-1:0]] : '0);
        end
        seq_accum = '0;
    endfunction

    // Applies one accepted item to the model and returns the result it owes.
    function automatic t_frame_result predict_frame(t_anim_item it);
        int acc;
        t_frame_result r;
        case (it.kind)
            sfs_pkg::KIND_TICK: begin
                if (seq_paused || seq_halted) begin
                    seq_active = 1'b0;
                end else begin
                    acc = int'(seq_accum) + int'(it.delta);
                    if (acc > 24'hFFFFFF) begin
                        acc = 24'hFFFFFF;
                    end
                    seq_accum = acc[ACCUM_W-1:0];
                    if (acc > int'(cfg_period)) begin
                        step_frame();
                    end
                end
            end
            sfs_pkg::KIND_PLAY: begin
                seq_accum = '0;
                seq_loops = '0;
                seq_pos   = cfg_list_mode ? '0 : cfg_start;
                if (it.flag) begin
                    seq_paused = 1'b0;
                    seq_halted = 1'b0;
                    seq_active = 1'b1;
                end
            end
            sfs_pkg::KIND_PAUSE: begin
                seq_paused = it.flag;
            end
            sfs_pkg::KIND_STOP: begin
                seq_halted = it.flag;
                if (it.flag) begin
                    seq_active = 1'b0;
                end
            end
            sfs_pkg::KIND_SELECT: begin
                seq_paused = 1'b1;
                place_origin(it.sprite);
            end
            sfs_pkg::KIND_LIST: begin
                sheet_list[it.slot] = it.sprite;
            end
            default: begin
            end
        endcase
        r.rect_x      = org_x;
        r.rect_y      = org_y;
        r.frame_index = seq_pos;
        r.playing     = seq_active;
        r.stopped     = seq_halted;
        return r;
    endfunction

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------
    function automatic t_anim_item mk(logic [KIND_W-1:0] kind, int delta, int flag,
                                      int sprite, int slot);
        t_anim_item it;
        it.kind   = kind;
        it.delta  = delta[DELTA_W-1:0];
        it.flag   = flag[0];
        it.sprite = sprite[IDX_W-1:0];
        it.slot   = slot[SLOT_W-1:0];
        return it;
    endfunction

    function automatic t_stim_row row_item(t_anim_item it);
        t_stim_row r;
        r = '0;
        r.op   = ROW_ITEM;
        r.item = it;
        return r;
    endfunction

    function automatic t_stim_row row_want(t_anim_item it, int x, int y, int idx,
                                           int play, int stop);
        t_stim_row r;
        r = row_item(it);
        r.pinned = 1'b1;
        r.want   = '{x[COORD_W-1:0], y[COORD_W-1:0], idx[IDX_W-1:0], play[0], stop[0]};
        return r;
    endfunction

    function automatic t_stim_row row_cfg(sfs_pkg::t_cfg_reg sel, int val);
        t_stim_row r;
        r = '0;
        r.op      = ROW_CFG;
        r.cfg_sel = sel;
        r.cfg_val = val[CFG_DAT_W-1:0];
        return r;
    endfunction

    function automatic int rand_delta();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 0;
        if (r < 20) return 65535;
        if (r < 70) return $urandom_range(1500);
        return $urandom_range(65535);
    endfunction

    // Mostly ticks, with the control kinds mixed in and a little noise.
    function automatic t_anim_item rand_item();
        int r;
        r = $urandom_range(99);
        if (r < 62) return mk(sfs_pkg::KIND_TICK, rand_delta(), $urandom_range(1), 0, 0);
        if (r < 70) return mk(sfs_pkg::KIND_PLAY, 0, int'($urandom_range(9) != 0), 0, 0);
        if (r < 77) return mk(sfs_pkg::KIND_PAUSE, 0, $urandom_range(1), 0, 0);
        if (r < 82) return mk(sfs_pkg::KIND_STOP, 0, int'($urandom_range(3) == 0), 0, 0);
        if (r < 88) return mk(sfs_pkg::KIND_SELECT, $urandom_range(65535), $urandom_range(1),
                              $urandom_range(1023), $urandom_range(63));
        if (r < 95) return mk(sfs_pkg::KIND_LIST, 0, $urandom_range(1), $urandom_range(1023),
                              $urandom_range(63));
        return mk($urandom_range(1) ? KIND_SPARE_6 : KIND_SPARE_7, $urandom_range(65535),
                  $urandom_range(1), $urandom_range(1023), $urandom_range(63));
    endfunction

    function automatic int pick_edge(int lo, int hi, int typ_hi);
        int r;
        r = $urandom_range(9);
        if (r == 0) return lo;
        if (r == 1) return hi;
        if (r == 2) return $urandom_range(hi, lo);
        return $urandom_range(typ_hi, lo);
    endfunction

    task automatic set_idle(int mode);
        case (mode)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 57; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 57; end
            default: begin gap_pct = 23; stall_pct = 23; end
        endcase
    endtask

    // Offers one item, with random idle cycles first, and records its result
    // once the block takes it.
    task automatic push_item(t_anim_item it, logic pinned, t_frame_result want);
        t_frame_result pred;
        @(negedge i_clk);
        while ($urandom_range(99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W - 33){1'b0}}, it.slot, it.sprite, it.flag, it.delta};
        s_axis_tuser  <= it.kind;
        do @(posedge i_clk); while (!s_axis_tready);
        pred = predict_frame(it);
        frame_q.push_back(pinned ? want : pred);
    endtask

    // Stops offering items and lets every owed result drain out.
    task automatic settle();
        @(negedge i_clk) s_axis_tvalid <= 1'b0;
        while (frame_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(sfs_pkg::t_cfg_reg sel, int val);
        logic [CFG_DAT_W-1:0] v;
        v = val[CFG_DAT_W-1:0];
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= v;
        @(negedge i_clk) i_cfg_we <= 1'b0;
        case (sel)
            sfs_pkg::CFG_LIST_MODE: cfg_list_mode = v[0];
            sfs_pkg::CFG_START:     cfg_start     = v[IDX_W-1:0];
            sfs_pkg::CFG_END:       cfg_end       = v[IDX_W-1:0];
            sfs_pkg::CFG_LOOP_LIM:  cfg_loop_lim  = v[LOOP_W-1:0];
            sfs_pkg::CFG_COLUMNS:   cfg_cols      = v[COLS_W-1:0];
            sfs_pkg::CFG_FRAME_W:   cfg_fw        = v[SIZE_W-1:0];
            sfs_pkg::CFG_FRAME_H:   cfg_fh        = v[SIZE_W-1:0];
            sfs_pkg::CFG_PERIOD:    cfg_period    = v[ACCUM_W-1:0];
            default: ;
        endcase
    endtask

    // Fresh register set for a playback phase, leaning on the extremes.
    task automatic configure_random();
        int r;
        int start_v;
        int lim;
        settle();
        start_v = pick_edge(0, 1023, 20);
        write_reg(sfs_pkg::CFG_LIST_MODE, $urandom_range(1));
        write_reg(sfs_pkg::CFG_START, start_v);
        r = $urandom_range(9);
        if (r == 0) begin
            write_reg(sfs_pkg::CFG_END, 0);
        end else if (r == 1) begin
            write_reg(sfs_pkg::CFG_END, 1023);
        end else begin
            write_reg(sfs_pkg::CFG_END, (start_v + $urandom_range(8)) % 1024);
        end
        r = $urandom_range(9);
        if (r < 3) lim = -1;
        else if (r < 7) lim = $urandom_range(5);
        else if (r == 7) lim = 32767;
        else lim = $urandom_range(65535);
        write_reg(sfs_pkg::CFG_LOOP_LIM, lim & 16'hFFFF);
        write_reg(sfs_pkg::CFG_COLUMNS, ($urandom_range(9) == 0) ? 0 : pick_edge(1, 127, 64));
        write_reg(sfs_pkg::CFG_FRAME_W, pick_edge(0, 1023, 1023));
        write_reg(sfs_pkg::CFG_FRAME_H, pick_edge(0, 1023, 1023));
        r = $urandom_range(19);
        if (r == 0) write_reg(sfs_pkg::CFG_PERIOD, 24'hFFFFFF);
        else if (r == 1) write_reg(sfs_pkg::CFG_PERIOD, $urandom_range(24'hFFFFFF));
        else write_reg(sfs_pkg::CFG_PERIOD, pick_edge(0, 3000, 3000));
    endtask

    // -----------------------------------------------------------------------
    // Receiver: random backpressure, and result checking
    // -----------------------------------------------------------------------
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        t_frame_result got;
        t_frame_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.rect_x      = m_axis_tdata[15:0];
            got.rect_y      = m_axis_tdata[31:16];
            got.frame_index = m_axis_tdata[41:32];
            got.playing     = m_axis_tdata[42];
            got.stopped     = m_axis_tdata[43];
            if (frame_q.size() == 0) begin
                $error("result item with none owed: %p", got);
                err_count++;
            end else begin
                want = frame_q.pop_front();
                if (got.rect_x !== want.rect_x) begin
                    $error("rect_x: expected %0d, got %0d", want.rect_x, got.rect_x);
                    err_count++;
                end
                if (got.rect_y !== want.rect_y) begin
                    $error("rect_y: expected %0d, got %0d", want.rect_y, got.rect_y);
                    err_count++;
                end
                if (got.frame_index !== want.frame_index) begin
                    $error("frame_index: expected %0d, got %0d",
                           want.frame_index, got.frame_index);
                    err_count++;
                end
                if (got.playing !== want.playing) begin
                    $error("playing: expected %0d, got %0d", want.playing, got.playing);
                    err_count++;
                end
                if (got.stopped !== want.stopped) begin
                    $error("stopped: expected %0d, got %0d", want.stopped, got.stopped);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: too long with no item moving on either side ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial begin
        t_stim_row directed_rows [$];
        t_stim_row row;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Reset defaults: range 0..1, one column, 16x16 frames, period 100000.
        directed_rows.push_back(row_want(mk(sfs_pkg::KIND_TICK, 65535, 0, 0, 0),
                                         0, 0, 0, 0, 0));
        directed_rows.push_back(row_item(mk(sfs_pkg::KIND_TICK, 34466, 0, 0, 0))); // past period
        directed_rows.push_back(row_want(mk(sfs_pkg::KIND_PLAY, 0, 1, 0, 0),
                                         0, 0, 0, 1, 0));
        directed_rows.push_back(row_want(mk(sfs_pkg::KIND_SELECT, 0, 0, 1023, 0),
                                         0, 16368, 0, 1, 0));
        directed_rows.push_back(row_want(mk(sfs_pkg::KIND_TICK, 5, 0, 0, 0),
                                         0, 16368, 0, 0, 0));
        directed_rows.push_back(row_item(mk(sfs_pkg::KIND_PAUSE, 0, 0, 0, 0)));
        directed_rows.push_back(row_item(mk(sfs_pkg::KIND_PLAY, 0, 0, 0, 0)));  // restart only
        directed_rows.push_back(row_want(mk(sfs_pkg::KIND_STOP, 0, 1, 0, 0),
                                         0, 16368, 0, 0, 1));
        directed_rows.push_back(row_item(mk(sfs_pkg::KIND_TICK, 65535, 0, 0, 0))); // halted
        directed_rows.push_back(row_want(mk(sfs_pkg::KIND_PLAY, 0, 1, 0, 0),
                                         0, 16368, 0, 1, 0));
        directed_rows.push_back(row_item(mk(KIND_SPARE_6, 65535, 1, 1023, 63)));
        directed_rows.push_back(row_item(mk(KIND_SPARE_7, 0, 0, 0, 0)));
        directed_rows.push_back(row_item(mk(sfs_pkg::KIND_LIST, 0, 0, 1023, 0)));
        directed_rows.push_back(row_item(mk(sfs_pkg::KIND_LIST, 0, 1, 0, 1)));
        directed_rows.push_back(row_item(mk(sfs_pkg::KIND_LIST, 0, 0, 517, 2)));
        directed_rows.push_back(row_item(mk(sfs_pkg::KIND_LIST, 65535, 1, 1023, 63)));
        // zero columns, largest frames, zero period, start beyond end, limit 1
        directed_rows.push_back(row_cfg(sfs_pkg::CFG_COLUMNS, 0));
        directed_rows.push_back(row_cfg(sfs_pkg::CFG_FRAME_W, 1023));
        directed_rows.push_back(row_cfg(sfs_pkg::CFG_FRAME_H, 1023));
        directed_rows.push_back(row_cfg(sfs_pkg::CFG_PERIOD, 0));
        directed_rows.push_back(row_cfg(sfs_pkg::CFG_START, 1023));
        directed_rows.push_back(row_cfg(sfs_pkg::CFG_END, 0));
        directed_rows.push_back(row_cfg(sfs_pkg::CFG_LOOP_LIM, 1));
        directed_rows.push_back(row_want(mk(sfs_pkg::KIND_PLAY, 0, 1, 0, 0),
                                         0, 16368, 1023, 1, 0));
        directed_rows.push_back(row_item(mk(sfs_pkg::KIND_TICK, 0, 0, 0, 0)));  // not past zero
        directed_rows.push_back(row_want(mk(sfs_pkg::KIND_TICK, 1, 0, 0, 0),
                                         0, 65535, 1023, 1, 0));
        directed_rows.push_back(row_item(mk(sfs_pkg::KIND_TICK, 65535, 0, 0, 0))); // halts
        // list mode over three entries, negative limit other than forever
        directed_rows.push_back(row_cfg(sfs_pkg::CFG_LIST_MODE, 1));
        directed_rows.push_back(row_cfg(sfs_pkg::CFG_END, 3));
        directed_rows.push_back(row_cfg(sfs_pkg::CFG_LOOP_LIM, 16'hFFFE));
        directed_rows.push_back(row_cfg(sfs_pkg::CFG_COLUMNS, 64));
        directed_rows.push_back(row_item(mk(sfs_pkg::KIND_PLAY, 0, 1, 0, 0)));
        directed_rows.push_back(row_item(mk(sfs_pkg::KIND_TICK, 1, 0, 0, 0)));
        directed_rows.push_back(row_item(mk(sfs_pkg::KIND_TICK, 1, 0, 0, 0)));
        directed_rows.push_back(row_item(mk(sfs_pkg::KIND_TICK, 1, 0, 0, 0)));
        // empty list keeps replaying entry 0
        directed_rows.push_back(row_cfg(sfs_pkg::CFG_END, 0));
        directed_rows.push_back(row_item(mk(sfs_pkg::KIND_PLAY, 0, 1, 0, 0)));
        directed_rows.push_back(row_item(mk(sfs_pkg::KIND_TICK, 1, 0, 0, 0)));

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.op == ROW_CFG) begin
                settle();
                write_reg(row.cfg_sel, int'(row.cfg_val));
            end else begin
                push_item(row.item, row.pinned, row.want);
            end
        end

        // Fill the whole list so list playback never reads an empty slot.
        set_idle(3);
        for (int s = 0; s < SHEET_SLOTS; s++) begin
            push_item(mk(sfs_pkg::KIND_LIST, $urandom_range(65535), $urandom_range(1),
                         $urandom_range(1023), s), 1'b0, '0);
        end

        // Random playback phases, each opened by a full play.
        for (int ph = 0; ph < 8; ph++) begin
            configure_random();
            set_idle(ph % 4);
            push_item(mk(sfs_pkg::KIND_PLAY, 0, 1, 0, 0), 1'b0, '0);
            for (int n = 0; n < 18; n++) begin
                push_item(rand_item(), 1'b0, '0);
            end
        end

        // Near-maximum period: the accumulator has to clamp before it passes.
        settle();
        write_reg(sfs_pkg::CFG_LIST_MODE, 0);
        write_reg(sfs_pkg::CFG_START, 0);
        write_reg(sfs_pkg::CFG_END, 1023);
        write_reg(sfs_pkg::CFG_LOOP_LIM, 16'hFFFF);
        write_reg(sfs_pkg::CFG_PERIOD, 24'hFFFFF0);
        set_idle(0);
        push_item(mk(sfs_pkg::KIND_PLAY, 0, 1, 0, 0), 1'b0, '0);
        for (int n = 0; n < 260; n++) begin
            if (n == 130) set_idle(3);
            push_item(mk(sfs_pkg::KIND_TICK, 65535, 0, 0, 0), 1'b0, '0);
        end

        settle();
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sprite_frame_sequencer.f =====
+incdir+rtl/core
rtl/core/sfs_pkg.sv
rtl/core/sprite_frame_sequencer.sv
dv/testbench.sv
